FILE: design/autokey_byte_cipher_unit_macros.svh
// Assertion helpers for the cipher unit, used by abc_keystep.
// Each macro expects clk and arst_n in scope.
`ifndef AUTOKEY_BYTE_CIPHER_UNIT_MACROS_SVH
`define AUTOKEY_BYTE_CIPHER_UNIT_MACROS_SVH

// same-cycle implication
`define ABC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ABC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/abc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abc_pkg;

	localparam int KeyWidth  = 31;
	localparam int FoldShift = 29;
	localparam int ByteWidth = 8;

	localparam logic [KeyWidth-1:0] SaltModulus = 31'd20857;
	localparam logic [KeyWidth-1:0] SaltLast    = SaltModulus - 31'd1;

	localparam logic OpRestart = 1'b0;
	localparam logic OpData    = 1'b1;

	typedef logic [KeyWidth-1:0]  word_t;
	typedef logic [ByteWidth-1:0] byte_t;

	typedef struct packed {
		logic  op;
		byte_t data;
	} item_t;

endpackage

`default_nettype wire

FILE: design/abc_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module abc_in_reg (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  wire            op,
	input  wire  [7:0]     data_byte,
	input  wire            adv,
	output logic           valid_s1,
	output abc_pkg::item_t item_s1
);
	import abc_pkg::*;

	logic accept;

	assign in_stall = valid_s1 & ~adv;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op   <= op;
			item_s1.data <= data_byte;
		end
	end

endmodule

`default_nettype wire

FILE: design/abc_keystep.sv
`timescale 1ns / 1ps
`default_nettype none

`include "autokey_byte_cipher_unit_macros.svh"

module abc_keystep (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 init_we,
	input  wire  [30:0]         init_wdata,
	input  wire                 step,
	input  wire abc_pkg::item_t item,
	output abc_pkg::byte_t      res
);
	import abc_pkg::*;

	word_t init_q;
	word_t key_q;
	word_t salt_q;

	logic [FoldShift-1:0] k_fold;
	byte_t                mix;
	word_t                salt_next;
	word_t                key_next;
	logic                 data_beat;
	logic                 load_beat;

	// fold the top two key bits into the low end
	assign k_fold    = key_q[FoldShift-1:0]
	                 ^ {{(FoldShift-2){1'b0}}, key_q[KeyWidth-1:FoldShift]};
	assign res       = k_fold[ByteWidth-1:0] - item.data;
	assign mix       = res ^ item.data;
	assign salt_next = (salt_q >= SaltLast) ? '0 : salt_q + 31'd1;
	assign key_next  = {1'b0, k_fold, 1'b0}
	                 + {{(KeyWidth-ByteWidth){1'b0}}, mix}
	                 + salt_next;

	assign data_beat = step & (item.op == OpData);
	assign load_beat = step & (item.op == OpRestart);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			key_q  <= '0;
			salt_q <= '0;
		end else begin
			if (init_we) begin
				init_q <= init_wdata;
			end
			if (step) begin
				unique case (item.op)
					OpRestart: begin
						key_q  <= init_q;
						salt_q <= init_q;
					end
					OpData: begin
						key_q  <= key_next;
						salt_q <= salt_next;
					end
					default: begin
						key_q  <= key_q;
						salt_q <= salt_q;
					end
				endcase
			end
		end
	end

	`ABC_ASSERT_NXT(a_salt_wrapped, data_beat, salt_q < SaltModulus, "salt out of range")
	`ABC_ASSERT_NXT(a_reload, load_beat, key_q == $past(init_q) && salt_q == key_q, "bad reload")
	`ABC_ASSERT_NXT(a_state_hold, !step, $stable(key_q) && $stable(salt_q), "state moved")

endmodule

`default_nettype wire

FILE: design/abc_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module abc_out_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  wire abc_pkg::byte_t res,
	output logic                ready,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [7:0]          result_byte
);
	import abc_pkg::*;

	assign ready = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			result_byte <= res;
		end
	end

endmodule

`default_nettype wire

FILE: design/autokey_byte_cipher_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Autokey byte cipher: one byte in per cycle when not stalled; the same rule
// encrypts and decrypts. A beat with op = 0 reloads key and salt from
// init_value and gives no result; a beat with op = 1 gives one result_byte,
// registered in abc_in_reg and then in abc_out_reg. The sustained rate is one
// byte per clock while out_stall is low, set by the key update (fold, subtract,
// three-term add) that is combinational in abc_keystep. Write init_value only
// while no beats are in flight.
module autokey_byte_cipher_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         init_we,
	input  wire  [30:0] init_value,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         op,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  result_byte
);
	import abc_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  adv;
	logic  ready;
	logic  step;
	byte_t res;

	// restart beats never wait on the output side
	assign adv  = (item_s1.op == OpRestart) | ready;
	assign step = valid_s1 & adv;

	abc_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.data_byte (data_byte),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	abc_keystep u_keystep (
		.clk        (clk),
		.arst_n     (arst_n),
		.init_we    (init_we),
		.init_wdata (init_value),
		.step       (step),
		.item       (item_s1),
		.res        (res)
	);

	abc_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (step & (item_s1.op == OpData)),
		.res         (res),
		.ready       (ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_byte (result_byte)
	);

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import abc_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int SettleTicks = 8;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        init_we    = 1'b0;
	word_t       init_value = '0;
	logic        in_valid   = 1'b0;
	logic        op         = OpRestart;
	byte_t       data_byte  = '0;
	logic        out_stall  = 1'b0;
	logic        in_stall;
	logic        out_valid;
	byte_t       result_byte;

	// shadow of the unit: init register, key and salt
	word_t       init_shadow = '0;
	word_t       key_state   = '0;
	word_t       salt_state  = '0;
	byte_t       expected_bytes[$];

	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          mismatches    = 0;
	int          bytes_checked = 0;
	int          restarts_seen = 0;
	int          init_writes   = 0;
	int          cycle_count   = 0;

	autokey_byte_cipher_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.init_we     (init_we),
		.init_value  (init_value),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_byte (result_byte)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// one data byte through the shadow key schedule
	function automatic byte_t cipher_byte(input byte_t din);
		word_t folded;
		word_t salt_next;
		byte_t res;
		folded = {2'b00, key_state[FoldShift-1:0]} ^ word_t'(key_state[KeyWidth-1:FoldShift]);
		res = folded[ByteWidth-1:0] - din;
		salt_next = salt_state + word_t'(1);
		if (salt_next >= SaltModulus)
			salt_next = '0;
		salt_state = salt_next;
		key_state = folded + folded + word_t'(res ^ din) + salt_next;
		return res;
	endfunction

	// predict on input beats, compare on output beats, all on one edge
	always @(posedge clk) begin
		byte_t want;
		if (arst_n) begin
			if (init_we) begin
				init_shadow = init_value;
				init_writes++;
			end
			if (in_valid && !in_stall) begin
				if (op == OpRestart) begin
					key_state = init_shadow;
					salt_state = init_shadow;
					restarts_seen++;
				end else begin
					expected_bytes.push_back(cipher_byte(data_byte));
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected result_byte %02h", result_byte));
				end else begin
					want = expected_bytes.pop_front();
					if (result_byte !== want)
						report_mismatch($sformatf("result_byte got %02h want %02h",
							result_byte, want));
					bytes_checked++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	task automatic send_beat(input logic beat_op, input byte_t beat_data);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= beat_op;
		data_byte <= beat_data;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid, drain results, then let the pipe settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SettleTicks) @(posedge clk);
	endtask

	task automatic write_init(input word_t value);
		wait_idle();
		@(negedge clk);
		init_we <= 1'b1;
		init_value <= value;
		@(negedge clk);
		init_we <= 1'b0;
	endtask

	task automatic send_message(input int len);
		send_beat(OpRestart, byte_t'($urandom()));
		for (int i = 0; i < len; i++)
			send_beat(OpData, byte_t'($urandom()));
	endtask

	task automatic test_reset_state();
		send_idle_pct = 0;
		stall_pct = 0;
		// key and salt start at zero without any restart
		send_beat(OpData, 8'h00);
		send_beat(OpData, 8'hFF);
		send_beat(OpData, 8'hA5);
	endtask

	task automatic test_full_key_fold();
		write_init(31'h7FFF_FFFF);
		// data field must be ignored on restart
		send_beat(OpRestart, 8'hFF);
		send_beat(OpData, 8'h00);
		send_beat(OpData, 8'hFF);
		send_beat(OpData, 8'h5A);
	endtask

	task automatic test_salt_wrap();
		write_init(SaltLast);
		send_beat(OpRestart, 8'h00);
		send_beat(OpData, 8'h3C);
		send_beat(OpData, 8'hC3);
		write_init(SaltModulus);
		send_beat(OpRestart, 8'h00);
		send_beat(OpData, 8'h81);
		write_init(SaltLast - word_t'(1));
		send_beat(OpRestart, 8'h7E);
		send_beat(OpData, 8'h01);
		send_beat(OpData, 8'h80);
	endtask

	task automatic test_back_to_back_restart();
		write_init('0);
		send_beat(OpRestart, 8'h55);
		send_beat(OpRestart, 8'hAA);
		send_beat(OpData, 8'h00);
		send_beat(OpData, 8'h01);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_in_pct,
		input int items);
		word_t cfg;
		int sent;
		int len;
		send_idle_pct = idle_pct;
		stall_pct = stall_in_pct;
		for (int seg = 0; seg < 4; seg++) begin
			case (seg)
				0: cfg = word_t'($urandom());
				1: begin
					case ($urandom_range(3))
						0: cfg = '0;
						1: cfg = 31'h7FFF_FFFF;
						2: cfg = SaltLast;
						default: cfg = SaltModulus;
					endcase
				end
				2: cfg = word_t'($urandom_range(SaltLast));
				default: cfg = word_t'($urandom()) | 31'h6000_0000;
			endcase
			write_init(cfg);
			sent = 0;
			while (sent < items / 4) begin
				len = $urandom_range(1, 12);
				case ($urandom_range(7))
					// run on without a restart
					0: begin
						for (int i = 0; i < len; i++)
							send_beat(OpData, byte_t'($urandom()));
						sent += len;
					end
					// repeated restart ahead of the message
					1: begin
						send_beat(OpRestart, byte_t'($urandom()));
						send_message(len);
						sent += len + 2;
					end
					default: begin
						send_message(len);
						sent += len + 1;
					end
				endcase
			end
		end
	endtask

	task automatic test_finish();
		wait_idle();
		if (expected_bytes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_bytes.size()));
		$display("Checked %0d result bytes over %0d restarts and %0d init_value writes,",
			bytes_checked, restarts_seen, init_writes);
		$display("with sender gaps and receiver stalls in four mixes.");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_reset_state();
		test_full_key_fold();
		test_salt_wrap();
		test_back_to_back_restart();
		test_random_phase(0, 0, 160);
		test_random_phase(83, 0, 160);
		test_random_phase(0, 83, 160);
		test_random_phase(22, 22, 160);
		test_finish();
	end

endmodule
